// ===== src/prg_pkg.sv =====
`default_nettype none

package prg_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 16;
  localparam int PRIME_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_COUNT = 2'd2;

  localparam int RANGE_START_RST = 2;
  localparam int FIRST_DIVISOR   = 2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_TEST  = 5'b01000,
    ST_FIN   = 5'b10000
  } prg_state_t;

endpackage

`default_nettype wire

// ===== src/prime_range_generator_top.sv =====
`default_nettype none

// Operation: from the accepting edge each candidate is examined in turn, and each trial
// divisor runs a bit-serial restoring divider over W bits (W = min(VALUE_BITS, 32)); the
// result is then loaded into the output register once that register is free or being read.
// Input: one beat at a time; the next input beat is taken only once the last result is
// loaded, and it is taken while that result waits in the output register.
// Reset (rst_n, synchronous): candidate = 2, given = 0, control registers to reset values; the datapath is not reset.
module prime_range_generator_top #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [prg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [prg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_restart,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [prg_pkg::PRIME_W-1:0]            out_prime,
  output logic                                   out_found,
  output logic                                   out_is_last
);
  import prg_pkg::*;

  localparam int RW    = (VALUE_BITS < CFG_DATA_W) ? VALUE_BITS : CFG_DATA_W;
  localparam int CNT_W = $clog2(RW + 1);

  prg_state_t           state_r, state_nxt;
  logic [RW-1:0]        range_start_r, range_end_r;
  logic [COUNT_W-1:0]   prime_count_r;
  logic [RW-1:0]        cand_r, cand_nxt;
  logic [COUNT_W-1:0]   given_r, given_nxt;
  logic [RW-1:0]        tst_r, tst_nxt;
  logic [RW-1:0]        dvs_r, dvs_nxt;
  logic [RW-1:0]        quo_r, quo_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_last_r, res_last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RW-1:0]        out_val_r, out_val_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_last_r, out_last_nxt;

  // divider step
  logic [RW:0]          rem_sh;
  logic [RW:0]          rem_sub;
  logic                 div_ge;
  logic [COUNT_W-1:0]   given_inc;

  assign rem_sh    = {rem_r, quo_r[RW-1]};
  assign rem_sub   = rem_sh - {1'b0, dvs_r};
  assign div_ge    = rem_sh >= {1'b0, dvs_r};
  assign given_inc = given_r + COUNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    given_nxt     = given_r;
    tst_nxt       = tst_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cand_nxt  = range_start_r;
            given_nxt = '0;
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((given_r >= prime_count_r) || (cand_r >= range_end_r)) begin
          res_found_nxt = 1'b0;
          res_last_nxt  = 1'b0;
          state_nxt     = ST_FIN;
        end else begin
          cand_nxt = cand_r + RW'(1);
          if (cand_r >= RW'(FIRST_DIVISOR)) begin
            tst_nxt   = cand_r;
            dvs_nxt   = RW'(FIRST_DIVISOR);
            quo_nxt   = cand_r;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(RW);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        quo_nxt = {quo_r[RW-2:0], div_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (dvs_r > quo_r) begin
          // no divisor up to the square root: prime
          given_nxt     = given_inc;
          res_found_nxt = 1'b1;
          res_last_nxt  = (given_inc == prime_count_r);
          state_nxt     = ST_FIN;
        end else if (rem_r == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          dvs_nxt   = dvs_r + RW'(1);
          quo_nxt   = tst_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(RW);
          state_nxt = ST_DIV;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_last_nxt  = res_last_r;
          out_val_nxt   = res_found_r ? tst_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      range_start_r <= RW'(RANGE_START_RST);
      range_end_r   <= '0;
      prime_count_r <= '0;
      cand_r        <= RW'(RANGE_START_RST);
      given_r       <= '0;
      cnt_r         <= '0;
      res_found_r   <= 1'b0;
      res_last_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_found_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      given_r     <= given_nxt;
      cnt_r       <= cnt_nxt;
      res_found_r <= res_found_nxt;
      res_last_r  <= res_last_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RANGE_START: range_start_r <= cfg_wdata[RW-1:0];
          CFG_RANGE_END:   range_end_r   <= cfg_wdata[RW-1:0];
          CFG_PRIME_COUNT: prime_count_r <= cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tst_r     <= tst_nxt;
    dvs_r     <= dvs_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    out_val_r <= out_val_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_prime   = PRIME_W'(out_val_r);
  assign out_found   = out_found_r;
  assign out_is_last = out_last_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_prime == '0) && !out_is_last)
    else $error("miss beat carries nonzero payload");

  a_hit_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_prime >= PRIME_W'(FIRST_DIVISOR))
    else $error("reported prime below two");

  a_div_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dvs_r >= RW'(FIRST_DIVISOR))
    else $error("trial divisor below two");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=>
      (cand_r == $past(range_start_r)) && (given_r == '0))
    else $error("restart did not rewind scan");

endmodule

`default_nettype wire
